// ----- design/bcwf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcwf_pkg
// Shared types and constants for the barometer compensation filter.
// ----------------------------------------------------------------------------
package bcwf_pkg;

  localparam int DefFilterDepth = 8;
  localparam int NumRegs        = 6;

  localparam logic [2:0] RegSens       = 3'd0;
  localparam logic [2:0] RegOffset     = 3'd1;
  localparam logic [2:0] RegSensTc     = 3'd2;
  localparam logic [2:0] RegOffsetTc   = 3'd3;
  localparam logic [2:0] RegTref       = 3'd4;
  localparam logic [2:0] RegTempSens   = 3'd5;

  localparam logic signed [15:0] TempRef = 16'sd2000;
  localparam logic signed [15:0] TempMin = -16'sd4000;
  localparam logic signed [15:0] TempMax = 16'sd8500;
  localparam logic [16:0] PressMax = 17'd120000;

  localparam logic KindTemp  = 1'b0;
  localparam logic KindPress = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpTempDelta,   // dT = D2 - C5*256
    OpTempMul,     // dT*C6, form TEMP
    OpOffMul,      // C4*dT -> OFF
    OpSensMul,     // C3*dT -> SENS
    OpSqMul,       // (TEMP-2000)^2 correction
    OpPressLo,     // D1*SENS low partial
    OpPressHi,     // D1*SENS high partial, form P
    OpRingWr,      // write ring slot, clear sum
    OpAccum,       // accumulate one slot
    OpDivide,      // weighted sum / den
    OpLoadOut      // load output register
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       kind;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// ----- design/bcwf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcwf_datapath
// Shared multiplier, compensation registers, filter rings and divider.
// ----------------------------------------------------------------------------
module bcwf_datapath import bcwf_pkg::*; #(
  parameter int FilterDepth = DefFilterDepth,
  parameter int SlotW = (FilterDepth > 1) ? $clog2(FilterDepth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [23:0]        raw_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               kind_o,
  output logic signed [17:0] value_o,
  output logic signed [17:0] filt_o
);

  localparam int Den = FilterDepth * (FilterDepth + 1) / 2;
  localparam int SumW = 17 + $clog2(Den + 1) + 2;
  // floor(x / Den) == (x * RecipM) >> RecipShift for every x below 2^SumW
  localparam int RecipShift = SumW + $clog2(Den);
  localparam longint RecipM = ((64'sd1 <<< RecipShift) + longint'(Den) - 1) / Den;

  logic [15:0] cal_q [NumRegs];

  logic signed [24:0] dt_q, dt_d;
  logic signed [15:0] tc_q, tc_d;
  logic [23:0]        raw_q;
  logic signed [40:0] off_q;
  logic signed [40:0] sens_q;
  logic signed [48:0] plo_q;
  logic signed [17:0] val_q;
  logic signed [15:0] tring_q [FilterDepth];
  logic [16:0]        pring_q [FilterDepth];
  logic [SlotW-1:0]   tslot_q, pslot_q;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]    quo_q;
  logic               neg_q;
  logic               done_q;
  logic               kind_q;
  logic               out_k_q;
  logic signed [17:0] out_v_q, out_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cal_q[i] <= '0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < NumRegs)) begin
      cal_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // weighted sum magnitude, divided by the reciprocal multiply
  logic [SumW-1:0] absum;
  assign absum = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // single multiplier, operands chosen per op
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] mp;
  logic signed [16:0] tdiff;
  logic signed [24:0] sens_lo;
  assign tdiff = 17'(tc_q) - 17'(TempRef);
  assign sens_lo = $signed({1'b0, sens_q[23:0]});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      OpTempMul: begin ma = 34'(dt_q); mb = 34'($signed({1'b0, cal_q[RegTempSens]})); end
      OpOffMul:  begin ma = 34'(dt_q); mb = 34'($signed({1'b0, cal_q[RegOffsetTc]})); end
      OpSensMul: begin ma = 34'(dt_q); mb = 34'($signed({1'b0, cal_q[RegSensTc]})); end
      OpSqMul:   begin ma = 34'(tdiff); mb = 34'(tdiff); end
      OpPressLo: begin ma = 34'($signed({1'b0, raw_q})); mb = 34'(sens_lo); end
      OpPressHi: begin ma = 34'($signed({1'b0, raw_q})); mb = 34'($signed(sens_q[40:24])); end
      OpDivide:  begin ma = 34'($signed({1'b0, absum})); mb = 34'(RecipM); end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  logic signed [40:0] tnew;
  logic signed [63:0] ph;
  logic signed [63:0] pfull, pp;
  logic signed [40:0] sq5;

  always_comb begin
    dt_d = 25'($signed({1'b0, raw_i})) - 25'($signed({1'b0, cal_q[RegTref], 8'd0}));
    tnew = 41'(mp >>> 23) + 41'(TempRef);
    if (tnew < 41'(TempMin)) tc_d = TempMin;
    else if (tnew > 41'(TempMax)) tc_d = TempMax;
    else tc_d = tnew[15:0];
    sq5 = 41'(mp) * 41'sd5;
    ph = 64'(mp) <<< 24;
    pfull = ph + 64'(plo_q);
    pp = ((pfull >>> 21) - 64'(off_q)) >>> 15;
  end

  logic signed [SumW-1:0] slot_v;
  always_comb begin
    if (kind_q == KindTemp) slot_v = SumW'(tring_q[cmd_i.idx[SlotW-1:0]]);
    else slot_v = SumW'($signed({1'b0, pring_q[cmd_i.idx[SlotW-1:0]]}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= '0;
      tc_q <= TempRef;
      raw_q <= '0;
      tslot_q <= '0;
      pslot_q <= '0;
      for (int i = 0; i < FilterDepth; i++) begin
        tring_q[i] <= '0;
        pring_q[i] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OpTempDelta: begin dt_q <= dt_d; kind_q <= KindTemp; raw_q <= raw_i; end
        OpTempMul: begin tc_q <= tc_d; val_q <= 18'(tc_d); end
        OpOffMul: begin
          kind_q <= KindPress;
          raw_q <= raw_i;
          off_q <= 41'($signed({1'b0, cal_q[RegOffset], 16'd0})) + 41'(mp >>> 7);
        end
        OpSensMul:
          sens_q <= 41'($signed({1'b0, cal_q[RegSens], 15'd0})) + 41'(mp >>> 8);
        OpSqMul: if (tc_q < TempRef) begin
          off_q <= off_q - (sq5 >>> 1);
          sens_q <= sens_q - (sq5 >>> 2);
        end
        OpPressLo: plo_q <= 49'(mp);
        OpPressHi: begin
          if (pp < 0) val_q <= '0;
          else if (pp > 64'(PressMax)) val_q <= 18'(PressMax);
          else val_q <= pp[17:0];
        end
        OpRingWr: begin
          sum_q <= '0;
          done_q <= 1'b0;
          if (kind_q == KindTemp) begin
            tring_q[tslot_q] <= val_q[15:0];
            tslot_q <= (int'(tslot_q) == FilterDepth - 1) ? '0 : tslot_q + 1'b1;
          end else begin
            pring_q[pslot_q] <= val_q[16:0];
            pslot_q <= (int'(pslot_q) == FilterDepth - 1) ? '0 : pslot_q + 1'b1;
          end
        end
        OpAccum: begin
          sum_q <= sum_q + slot_v * SumW'(cmd_i.idx + 5'd1);
        end
        OpDivide: begin
          neg_q <= sum_q[SumW-1];
          quo_q <= SumW'(mp >>> RecipShift);
          done_q <= 1'b1;
        end
        OpLoadOut: begin
          out_k_q <= kind_q;
          out_v_q <= val_q;
          out_f_q <= neg_q ? 18'(-$signed(quo_q)) : 18'(quo_q);
        end
        default: ;
      endcase
    end
  end

  assign status_o.div_done = done_q;
  assign kind_o  = out_k_q;
  assign value_o = out_v_q;
  assign filt_o  = out_f_q;

endmodule

// ----- design/bcwf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcwf_ctrl
// Sequencer: accepts a word, steps the datapath, holds the result word.
// ----------------------------------------------------------------------------
module bcwf_ctrl import bcwf_pkg::*; #(
  parameter int FilterDepth = DefFilterDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] STmul  = 4'd1;
  localparam logic [3:0] SOff   = 4'd2;
  localparam logic [3:0] SSens  = 4'd3;
  localparam logic [3:0] SSq    = 4'd4;
  localparam logic [3:0] SPlo   = 4'd5;
  localparam logic [3:0] SPhi   = 4'd6;
  localparam logic [3:0] SRing  = 4'd7;
  localparam logic [3:0] SAcc   = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SLoad  = 4'd10;
  localparam logic [3:0] SWait  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [4:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic       take;

  // input held in the port while stalled; raw is captured into the datapath at accept
  assign take = in_valid_i && (state_q == SIdle);
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    ov_d = ov_q && out_stall_i;
    cmd_o.op = OpNone;
    cmd_o.kind = in_kind_i;
    cmd_o.idx = idx_q;
    unique case (state_q)
      SIdle: if (take) begin
        if (in_kind_i == KindTemp) begin
          cmd_o.op = OpTempDelta;
          state_d = STmul;
        end else begin
          cmd_o.op = OpOffMul;
          state_d = SSens;
        end
      end
      STmul: begin cmd_o.op = OpTempMul; state_d = SRing; end
      SOff:  state_d = SSens;
      SSens: begin cmd_o.op = OpSensMul; state_d = SSq; end
      SSq:   begin cmd_o.op = OpSqMul; state_d = SPlo; end
      SPlo:  begin cmd_o.op = OpPressLo; state_d = SPhi; end
      SPhi:  begin cmd_o.op = OpPressHi; state_d = SRing; end
      SRing: begin cmd_o.op = OpRingWr; idx_d = '0; state_d = SAcc; end
      SAcc: begin
        cmd_o.op = OpAccum;
        if (int'(idx_q) == FilterDepth - 1) state_d = SDiv;
        else idx_d = idx_q + 5'd1;
      end
      SDiv: begin
        cmd_o.op = OpDivide;
        if (status_i.div_done) state_d = SWait;
      end
      SWait: if (!ov_q || !out_stall_i) begin
        state_d = SLoad;
      end
      SLoad: begin
        cmd_o.op = OpLoadOut;
        ov_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SLoad) |-> (!ov_q || !out_stall_i))
    else $error("result word overwritten");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o)
    else $error("input taken mid item");
  a_ov_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == SLoad)
    else $error("result word without load");

endmodule

// ----- design/baro_compensate_weighted_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_compensate_weighted_filter
// Barometer temperature/pressure compensation with weighted ring averages.
// ----------------------------------------------------------------------------
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_stall_o    | action_i, raw_sample_i
// out     | output    | out_valid_o / out_stall_i  | result_kind_o, sample_value_o,
//         |           |                            | filtered_value_o
// cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One word at a time through a shared multiplier; from accept to next accept
// the sequencer runs the setup multiplies, the ring write, one accumulate per
// slot, the reciprocal divide, one wait check and one load.
// in_stall_o is high while a word is in work; raw_sample_i is captured at accept.
// Reset clears the rings, slots, dT, and sets temperature to 2000.
// A held result stalls the next load only, not the compute.
// ----------------------------------------------------------------------------
module baro_compensate_weighted_filter import bcwf_pkg::*; #(
  parameter int FILTER_DEPTH = DefFilterDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [23:0]        raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic signed [17:0] sample_value_o,
  output logic signed [17:0] filtered_value_o
);

  cmd_t    cmd;
  status_t status;

  bcwf_ctrl #(.FilterDepth(FILTER_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_kind_i(action_i), .in_stall_o,
    .out_valid_o, .out_stall_i, .status_i(status), .cmd_o(cmd)
  );

  bcwf_datapath #(.FilterDepth(FILTER_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .raw_i(raw_sample_i),
    .cmd_i(cmd), .status_o(status), .kind_o(result_kind_o),
    .value_o(sample_value_o), .filt_o(filtered_value_o)
  );

endmodule

// ----- dv/bcwf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcwf_checker
// Watches the config port and both channels of the barometer compensation
// filter. It keeps its own copy of the calibration, dT, temperature and
// rings, and compares each result word, field by field, with the oldest
// expected one.
// ----------------------------------------------------------------------------
module bcwf_checker import bcwf_pkg::*; #(
  parameter int FILTER_DEPTH = DefFilterDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic [23:0]        raw_sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               result_kind_i,
  input  logic signed [17:0] sample_value_i,
  input  logic signed [17:0] filtered_value_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 temp_words_o,
  output int                 press_words_o,
  output int                 clamped_o
);

  typedef struct packed {
    logic               kind;
    logic signed [17:0] value;
    logic signed [17:0] filt;
  } comp_result_t;

  comp_result_t result_q[$];

  longint c_sens, c_off, c_sens_tc, c_off_tc, c_tref, c_tsens;
  longint cur_dt, cur_temp;
  longint t_ring[FILTER_DEPTH];
  longint p_ring[FILTER_DEPTH];
  int     t_slot, p_slot;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // weighted average, slot i weighted by i+1, truncated toward zero
  function automatic longint weighted_avg(longint ring[FILTER_DEPTH]);
    longint acc;
    acc = 0;
    for (int i = 0; i < FILTER_DEPTH; i++) acc += ring[i] * (i + 1);
    return acc / (FILTER_DEPTH * (FILTER_DEPTH + 1) / 2);
  endfunction

  task automatic compensate(input logic kind, input logic [23:0] raw);
    longint raw_l, off, sens, d, sq, p, val, flt;
    comp_result_t r;
    raw_l = longint'(raw);
    if (kind == KindTemp) begin
      cur_dt = raw_l - c_tref * 256;
      // >>> on a signed longint floors
      cur_temp = clip(2000 + ((cur_dt * c_tsens) >>> 23), -4000, 8500);
      val = cur_temp;
      t_ring[t_slot] = val;
      t_slot = (t_slot + 1) % FILTER_DEPTH;
      flt = weighted_avg(t_ring);
      temp_words_o++;
      if (val == -4000 || val == 8500) clamped_o++;
    end else begin
      off  = c_off * 65536 + ((c_off_tc * cur_dt) >>> 7);
      sens = c_sens * 32768 + ((c_sens_tc * cur_dt) >>> 8);
      if (cur_temp < 2000) begin
        d = cur_temp - 2000;
        sq = d * d;
        off  -= (5 * sq) >>> 1;
        sens -= (5 * sq) >>> 2;
      end
      p = (((raw_l * sens) >>> 21) - off) >>> 15;
      val = clip(p, 0, 120000);
      p_ring[p_slot] = val;
      p_slot = (p_slot + 1) % FILTER_DEPTH;
      flt = weighted_avg(p_ring);
      press_words_o++;
      if (val == 0 || val == 120000) clamped_o++;
    end
    r.kind  = kind;
    r.value = val[17:0];
    r.filt  = flt[17:0];
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t exp_r;
    if (!rst_ni) begin
      c_sens = 0; c_off = 0; c_sens_tc = 0; c_off_tc = 0; c_tref = 0; c_tsens = 0;
      cur_dt = 0;
      cur_temp = 2000;
      t_slot = 0;
      p_slot = 0;
      for (int i = 0; i < FILTER_DEPTH; i++) begin
        t_ring[i] = 0;
        p_ring[i] = 0;
      end
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSens:     c_sens    = cfg_data_i;
          RegOffset:   c_off     = cfg_data_i;
          RegSensTc:   c_sens_tc = cfg_data_i;
          RegOffsetTc: c_off_tc  = cfg_data_i;
          RegTref:     c_tref    = cfg_data_i;
          RegTempSens: c_tsens   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word kind=%0b value=%0d filt=%0d",
                   $time, result_kind_i, sample_value_i, filtered_value_i);
          fail_count_o++;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.kind !== result_kind_i) begin
            $display("%0t: result_kind expected %0b got %0b", $time, exp_r.kind,
                     result_kind_i);
            fail_count_o++;
          end
          if (exp_r.value !== sample_value_i) begin
            $display("%0t: sample_value expected %0d got %0d", $time, exp_r.value,
                     sample_value_i);
            fail_count_o++;
          end
          if (exp_r.filt !== filtered_value_i) begin
            $display("%0t: filtered_value expected %0d got %0d", $time, exp_r.filt,
                     filtered_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) compensate(action_i, raw_sample_i);
    end
    pending_o = result_q.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    temp_words_o = 0;
    press_words_o = 0;
    clamped_o = 0;
  end

endmodule

// ----- dv/baro_compensate_weighted_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_compensate_weighted_filter_tb
// Drives calibration settings and raw temperature/pressure words into the
// compensation filter under random bursts and output stalls; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module baro_compensate_weighted_filter_tb;
  import bcwf_pkg::*;

  localparam longint CycleLimit = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = 1'b0;
  logic [23:0]        raw_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               result_kind_o;
  logic signed [17:0] sample_value_o;
  logic signed [17:0] filtered_value_o;

  int     fail_count, pending, temp_words, press_words, clamped;
  longint cycles = 0;
  logic   long_hold = 1'b0;
  int     burst_left = 0;
  logic [15:0] tref_now = 16'd0;

  always #2 clk_i = ~clk_i;

  baro_compensate_weighted_filter u_top (.*);

  bcwf_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .raw_sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_kind_i(result_kind_o),
    .sample_value_i(sample_value_o), .filtered_value_i(filtered_value_o),
    .fail_count_o(fail_count), .pending_o(pending), .temp_words_o(temp_words),
    .press_words_o(press_words), .clamped_o(clamped)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: stall modes change at random intervals; long hold on request
  initial begin
    int mode;
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 1) == 1);
          2: out_stall_i <= ($urandom_range(0, 9) < 8);
          default: out_stall_i <= ($urandom_range(0, 9) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic write_cal(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_cal(input logic [15:0] c1, c2, c3, c4, c5, c6);
    write_cal(RegSens, c1);
    write_cal(RegOffset, c2);
    write_cal(RegSensTc, c3);
    write_cal(RegOffsetTc, c4);
    write_cal(RegTref, c5);
    write_cal(RegTempSens, c6);
    cfg_we_i <= 1'b0;
    tref_now = c5;
    @(posedge clk_i);
  endtask

  // offer one word, hold it until taken; random gaps between bursts
  task automatic send_word(input logic kind, input logic [23:0] raw);
    in_valid_i <= 1'b1;
    action_i <= kind;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 80)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // raw temperature near the reference so the datapath stays in range mostly
  function automatic logic [23:0] near_tref(input int spread);
    longint v;
    v = longint'(tref_now) * 256 + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  task automatic random_words(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        send_word(KindTemp, near_tref($urandom_range(0, 1) ? 20000 : 2000000));
        send_word(KindPress, 24'($urandom_range(7000000, 11000000)));
        k++;
      end else begin
        send_word(logic'($urandom_range(0, 1)), 24'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // typical calibration
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_word(KindPress, 24'd9085466);   // pressure before any temperature
    send_word(KindTemp, 24'd8569150);
    send_word(KindPress, 24'd9085466);
    send_word(KindTemp, 24'd0);          // cold, clamps low
    send_word(KindPress, 24'd9085466);
    send_word(KindTemp, 24'hFFFFFF);     // hot, clamps high
    send_word(KindPress, 24'hFFFFFF);
    send_word(KindPress, 24'd0);
    send_word(KindTemp, 24'd8000000);    // below 20 degrees, second order
    send_word(KindPress, 24'd8000000);
    for (int i = 0; i < 9; i++) send_word(KindTemp, 24'd8569150 + 24'(i * 1000));
    drain();

    random_words(110);
    drain();

    // all ones, with a long output hold while the sender keeps going
    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    long_hold = 1'b1;
    random_words(110);
    drain();

    // all zero
    load_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(KindTemp, 24'hABCDEF);
    send_word(KindPress, 24'h123456);
    random_words(40);
    drain();

    load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
             16'($urandom()), 16'($urandom()));
    random_words(170);
    drain();

    $display("covered %0d temperature and %0d pressure words, %0d saturated,",
             temp_words, press_words, clamped);
    $display("over four calibration sets including all-zero and all-one words");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
